// ===== sv/dnsqfb_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsqfb_pkg
// Shared constants and types of the DNS query frame builder.
// ----------------------------------------------------------------------------
package dnsqfb_pkg;

  localparam int unsigned NameBytes = 256;
  localparam int unsigned MaxLabel  = 63;
  localparam int unsigned HdrBytes  = 54;

  localparam int unsigned NlW = $clog2(NameBytes + 1);
  localparam int unsigned NaW = $clog2(NameBytes);
  localparam int unsigned LlW = 7;
  localparam int unsigned PW  = $clog2(HdrBytes + NameBytes + 4 + 1);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEST_MAC   = 3'd0,
    REG_SRC_MAC    = 3'd1,
    REG_SRC_IP     = 3'd2,
    REG_DST_IP     = 3'd3,
    REG_QUERY_TYPE = 3'd4
  } reg_idx_e;

  localparam logic [7:0]  DotChar      = 8'h2E;
  localparam logic [15:0] EtherTypeIp  = 16'h0800;
  localparam logic [7:0]  IpVerIhl     = 8'h45;
  localparam logic [7:0]  IpTtl        = 8'h40;
  localparam logic [7:0]  IpProtoUdp   = 8'd17;
  localparam logic [15:0] IpFlagsDf    = 16'h4000;
  localparam logic [15:0] UdpSrcPort   = 16'd54321;
  localparam logic [15:0] UdpDstPort   = 16'd53;
  localparam logic [15:0] DnsFlagsRd   = 16'h0100;
  localparam logic [15:0] DnsOne       = 16'h0001;
  localparam logic [15:0] QtypeReset   = 16'h0001;

  // ip_len = name_length + 45, udp_len = name_length + 25
  localparam logic [15:0] IpLenBase  = 16'd45;
  localparam logic [15:0] UdpLenBase = 16'd25;
  localparam logic [PW-1:0] TailBytes = PW'(HdrBytes + 1 + 4);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_OPEN = 6'b000010,
    ST_CHAR = 6'b000100,
    ST_LEN  = 6'b001000,
    ST_CSUM = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

endpackage

// ===== sv/dns_query_frame_builder_unit.sv =====
// ----------------------------------------------------------------------------
// dns_query_frame_builder_unit
// Builds an Ethernet/IPv4/UDP DNS query frame from a streamed domain name.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one name character per beat,
//    has_char_i qualifies the character, last_i closes the name. The
//    transaction id is taken from the first beat of each name.
//  - Each beat steps through accept, then label open, character
//    write and length-byte update, the last three each at most a single write on the name store
//    port. in_ready_o is high only while the sequencer is idle.
//  - On a last beat the IPv4 checksum is summed one 16-bit word a cycle
//    (10 adds plus 2 folds), then the frame is assembled one byte a cycle
//    unless a finished word waits on the output register, from header logic
//    and the name store read port, name_length + 59 bytes in 64-bit beats (up to 40).
//  - Output channel (out_valid_o/out_ready_i) has an output register; when
//    the receiver stalls, the byte that completes the next word waits on it.
//  - Config port: cfg_ready_o is always high; writes belong in idle time.
//  - Reset clears config (query type to 1) and the name state. The name
//    store itself is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module dns_query_frame_builder_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dnsqfb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dnsqfb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      name_char_i,
  input  logic                            has_char_i,
  input  logic                            last_i,
  input  logic [15:0]                     transaction_id_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [63:0]                     frame_word_o,
  output logic [3:0]                      byte_count_o,
  output logic                            last_word_o,
  output logic                            overflow_o
);
  import dnsqfb_pkg::*;

  // config registers
  logic [47:0] dest_mac_q, src_mac_q;
  logic [31:0] src_ip_q, dst_ip_q;
  logic [15:0] qtype_q;

  state_e state_q, state_d;

  // captured beat
  logic [7:0]  chr_q;
  logic        last_q;

  // name state
  logic [NlW-1:0] nl_q, nl_d;
  logic [NaW-1:0] ls_q, ls_d;
  logic [LlW-1:0] ll_q, ll_d;
  logic [15:0]    tx_q;
  logic           first_q, first_d;
  logic           drop_q, drop_d;

  // checksum sequencer
  logic [3:0]  ck_cnt_q;
  logic [19:0] acc_q;
  logic [15:0] ck_q;

  // emission
  logic [PW-1:0] p_q, p_d;
  logic [63:0]   wbuf_q;
  logic [7:0]    rd_q;

  // name store
  logic [7:0]     mem [NameBytes];
  logic           we;
  logic [NaW-1:0] waddr, raddr;
  logic [7:0]     wdata;

  logic in_acc, open, room0, out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign open        = NlW'(ls_q) < nl_q;
  assign room0       = nl_q >= NlW'(NameBytes - 1);
  assign out_free    = !out_valid_o || out_ready_i;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_mac_q <= '0;
      src_mac_q  <= '0;
      src_ip_q   <= '0;
      dst_ip_q   <= '0;
      qtype_q    <= QtypeReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEST_MAC:   dest_mac_q <= cfg_data_i[47:0];
        REG_SRC_MAC:    src_mac_q  <= cfg_data_i[47:0];
        REG_SRC_IP:     src_ip_q   <= cfg_data_i[31:0];
        REG_DST_IP:     dst_ip_q   <= cfg_data_i[31:0];
        REG_QUERY_TYPE: qtype_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // lengths
  logic [15:0] ip_len, udp_len;
  logic [PW-1:0] total, name_end;
  assign ip_len   = 16'(nl_q) + IpLenBase;
  assign udp_len  = 16'(nl_q) + UdpLenBase;
  assign total    = PW'(nl_q) + TailBytes;
  assign name_end = PW'(nl_q) + PW'(HdrBytes);

  // checksum operand, one word per step
  logic [15:0] ck_word;
  always_comb begin
    case (ck_cnt_q)
      4'd0:    ck_word = {IpVerIhl, 8'h00};
      4'd1:    ck_word = ip_len;
      4'd3:    ck_word = IpFlagsDf;
      4'd4:    ck_word = {IpTtl, IpProtoUdp};
      4'd6:    ck_word = src_ip_q[31:16];
      4'd7:    ck_word = src_ip_q[15:0];
      4'd8:    ck_word = dst_ip_q[31:16];
      4'd9:    ck_word = dst_ip_q[15:0];
      default: ck_word = 16'h0000;
    endcase
  end

  // header byte at position p
  logic [7:0] hdr_byte;
  always_comb begin
    case (p_q[5:0])
      6'd0:  hdr_byte = dest_mac_q[47:40];
      6'd1:  hdr_byte = dest_mac_q[39:32];
      6'd2:  hdr_byte = dest_mac_q[31:24];
      6'd3:  hdr_byte = dest_mac_q[23:16];
      6'd4:  hdr_byte = dest_mac_q[15:8];
      6'd5:  hdr_byte = dest_mac_q[7:0];
      6'd6:  hdr_byte = src_mac_q[47:40];
      6'd7:  hdr_byte = src_mac_q[39:32];
      6'd8:  hdr_byte = src_mac_q[31:24];
      6'd9:  hdr_byte = src_mac_q[23:16];
      6'd10: hdr_byte = src_mac_q[15:8];
      6'd11: hdr_byte = src_mac_q[7:0];
      6'd12: hdr_byte = EtherTypeIp[15:8];
      6'd13: hdr_byte = EtherTypeIp[7:0];
      6'd14: hdr_byte = IpVerIhl;
      6'd16: hdr_byte = ip_len[15:8];
      6'd17: hdr_byte = ip_len[7:0];
      6'd20: hdr_byte = IpFlagsDf[15:8];
      6'd21: hdr_byte = IpFlagsDf[7:0];
      6'd22: hdr_byte = IpTtl;
      6'd23: hdr_byte = IpProtoUdp;
      6'd24: hdr_byte = ck_q[15:8];
      6'd25: hdr_byte = ck_q[7:0];
      6'd26: hdr_byte = src_ip_q[31:24];
      6'd27: hdr_byte = src_ip_q[23:16];
      6'd28: hdr_byte = src_ip_q[15:8];
      6'd29: hdr_byte = src_ip_q[7:0];
      6'd30: hdr_byte = dst_ip_q[31:24];
      6'd31: hdr_byte = dst_ip_q[23:16];
      6'd32: hdr_byte = dst_ip_q[15:8];
      6'd33: hdr_byte = dst_ip_q[7:0];
      6'd34: hdr_byte = UdpSrcPort[15:8];
      6'd35: hdr_byte = UdpSrcPort[7:0];
      6'd36: hdr_byte = UdpDstPort[15:8];
      6'd37: hdr_byte = UdpDstPort[7:0];
      6'd38: hdr_byte = udp_len[15:8];
      6'd39: hdr_byte = udp_len[7:0];
      6'd42: hdr_byte = tx_q[15:8];
      6'd43: hdr_byte = tx_q[7:0];
      6'd44: hdr_byte = DnsFlagsRd[15:8];
      6'd45: hdr_byte = DnsFlagsRd[7:0];
      6'd46: hdr_byte = DnsOne[15:8];
      6'd47: hdr_byte = DnsOne[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  // byte source: header, stored name, then terminator and question tail
  logic [7:0]    cur_byte;
  logic [PW-1:0] tail_off;
  assign tail_off = p_q - name_end;
  always_comb begin
    if (p_q < PW'(HdrBytes)) begin
      cur_byte = hdr_byte;
    end else if (p_q < name_end) begin
      cur_byte = rd_q;
    end else begin
      case (tail_off[2:0])
        3'd1:    cur_byte = qtype_q[15:8];
        3'd2:    cur_byte = qtype_q[7:0];
        3'd4:    cur_byte = DnsOne[7:0];
        default: cur_byte = 8'h00;
      endcase
    end
  end

  logic [63:0] word_new;
  logic        is_last_byte, word_done, adv;
  assign word_new     = wbuf_q | ({cur_byte, 56'h0} >> {p_q[2:0], 3'b000});
  assign is_last_byte = (p_q == total - PW'(1));
  assign word_done    = (p_q[2:0] == 3'd7) || is_last_byte;
  assign adv          = (state_q == ST_EMIT) && (!word_done || out_free);

  // sequencer
  always_comb begin
    state_d = state_q;
    nl_d    = nl_q;
    ls_d    = ls_q;
    ll_d    = ll_q;
    first_d = first_q;
    drop_d  = drop_q;
    we      = 1'b0;
    waddr   = nl_q[NaW-1:0];
    wdata   = 8'h00;
    p_d     = p_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          first_d = 1'b0;
          if (has_char_i)  state_d = ST_OPEN;
          else if (last_i) state_d = ST_CSUM;
        end
      end
      ST_OPEN: begin
        state_d = last_q ? ST_CSUM : ST_IDLE;
        if (chr_q == DotChar) begin
          if (open) begin
            ls_d = nl_q[NaW-1:0];
            ll_d = '0;
          end else if (!room0) begin
            we   = 1'b1;
            nl_d = nl_q + NlW'(1);
            ls_d = NaW'(nl_q + NlW'(1));
            ll_d = '0;
          end else begin
            drop_d = 1'b1;
          end
        end else if (open) begin
          state_d = ST_CHAR;
        end else if (room0) begin
          drop_d = 1'b1;
        end else begin
          // open a new label with a zero length byte
          we      = 1'b1;
          ls_d    = nl_q[NaW-1:0];
          nl_d    = nl_q + NlW'(1);
          ll_d    = '0;
          state_d = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (ll_q >= LlW'(MaxLabel) || room0) begin
          drop_d  = 1'b1;
          state_d = last_q ? ST_CSUM : ST_IDLE;
        end else begin
          we      = 1'b1;
          wdata   = chr_q;
          nl_d    = nl_q + NlW'(1);
          ll_d    = ll_q + LlW'(1);
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        we      = 1'b1;
        waddr   = ls_q;
        wdata   = 8'(ll_q);
        state_d = last_q ? ST_CSUM : ST_IDLE;
      end
      ST_CSUM: begin
        if (ck_cnt_q == 4'd11) begin
          state_d = ST_EMIT;
          p_d     = '0;
        end
      end
      ST_EMIT: begin
        if (adv) begin
          p_d = p_q + PW'(1);
          if (is_last_byte) begin
            state_d = ST_IDLE;
            nl_d    = '0;
            ls_d    = '0;
            ll_d    = '0;
            drop_d  = 1'b0;
            first_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic [PW-1:0] ridx;
  assign ridx  = p_d - PW'(HdrBytes);
  assign raddr = ridx[NaW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      chr_q  <= name_char_i;
      last_q <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nl_q        <= '0;
      ls_q        <= '0;
      ll_q        <= '0;
      tx_q        <= '0;
      first_q     <= 1'b1;
      drop_q      <= 1'b0;
      ck_cnt_q    <= '0;
      acc_q       <= '0;
      ck_q        <= '0;
      p_q         <= '0;
      wbuf_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      nl_q    <= nl_d;
      ls_q    <= ls_d;
      ll_q    <= ll_d;
      first_q <= first_d;
      drop_q  <= drop_d;
      p_q     <= p_d;
      if (in_acc && first_q) tx_q <= transaction_id_i;
      // checksum: ten adds, then two end-around folds
      if (state_q == ST_CSUM) begin
        ck_cnt_q <= ck_cnt_q + 4'd1;
        if (ck_cnt_q < 4'd10) begin
          acc_q <= acc_q + 20'(ck_word);
        end else if (ck_cnt_q == 4'd10) begin
          acc_q <= 20'(acc_q[19:16]) + 20'(acc_q[15:0]);
        end else begin
          ck_q <= ~(acc_q[15:0] + 16'(acc_q[16]));
        end
      end else begin
        ck_cnt_q <= '0;
        acc_q    <= '0;
      end
      // a finished word refills the output register in the cycle it drains
      if (adv && word_done) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (adv) begin
        if (word_done) begin
          wbuf_q <= '0;
        end else begin
          wbuf_q <= word_new;
        end
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (adv && word_done) begin
      frame_word_o <= word_new;
      byte_count_o <= 4'(p_q[2:0]) + 4'd1;
      last_word_o  <= is_last_byte;
      overflow_o   <= is_last_byte && drop_q;
    end
  end

  // checks
  a_nl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_q <= NlW'(NameBytes - 1))
    else $error("name length past store");
  a_ll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ll_q <= LlW'(MaxLabel))
    else $error("label length past limit");
  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_word_o |-> byte_count_o == 4'd8)
    else $error("short word before frame end");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !we && (state_q == ST_IDLE))
    else $error("input ready while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o != 4'd0 && byte_count_o <= 4'd8)
    else $error("bad byte count");

endmodule
